// File: sv/ethernet_console_connection_engine_top_macros.svh
// Assertion macros for the console connection engine.
// Used by the top level only.
`ifndef ETHERNET_CONSOLE_CONNECTION_ENGINE_TOP_MACROS_SVH
`define ETHERNET_CONSOLE_CONNECTION_ENGINE_TOP_MACROS_SVH
// Property that must hold at every edge outside reset.
`define ECCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on the next clock edge.
`define ECCE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

// File: sv/ecce_pkg.sv
// Package for the console connection engine: types, codes and constants.
// No dependencies.
`default_nettype none
package ecce_pkg;
  localparam int unsigned MacW   = 48;
  localparam int unsigned Slots  = 15;
  localparam int unsigned Ifaces = 4;
  localparam int unsigned SlotW  = $clog2(Slots);

  typedef enum logic [1:0] {
    KIND_PKT  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CONS = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [7:0] {
    PT_INITA = 8'd0,
    PT_INITB = 8'd1,
    PT_INITC = 8'd2,
    PT_DATA  = 8'd3,
    PT_ACK   = 8'd4,
    PT_DISC  = 8'd5,
    PT_OFFER = 8'd6,
    PT_RESET = 8'd7
  } pkt_type_e;

  typedef enum logic [2:0] {
    ACT_ACK     = 3'd0,
    ACT_INITB   = 3'd1,
    ACT_OFFER   = 3'd2,
    ACT_NEWDATA = 3'd3,
    ACT_RESEND  = 3'd4,
    ACT_DELIVER = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_INITB  = 2'd1,
    ST_OPEN   = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    CFG_IFACE_EN = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_RETRY    = 2'd2
  } cfg_idx_e;

  // Sequencer states of the back end.
  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_SCAN  = 3'd1,
    B_PKT   = 3'd2,
    B_EMIT2 = 3'd3,
    B_TICK  = 3'd4
  } back_state_e;

  localparam logic [3:0] TimeoutReset = 4'd4;
  localparam logic [3:0] RetryReset   = 4'd3;
  localparam int unsigned MaxResults  = 15;

  // Queue entry passed from front to back.
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      iface;
    logic [MacW-1:0] mac;
    logic [7:0]      pkt_type;
    logic [7:0]      conn_no;
    logic [7:0]      seq_no;
  } item_t;

  typedef struct packed {
    logic busy;
  } back_status_t;
endpackage
`default_nettype wire

// File: sv/ecce_front.sv
// Front end: accepts input transactions, drops packets of disabled interfaces
// and items of no kind, pushes the rest into a two-entry queue. Uses ecce_pkg.
`default_nettype none
module ecce_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ecce_pkg::item_t  item_i,
  input  wire logic [3:0]       iface_en_i,
  output logic                  q_valid_o,
  input  wire logic             q_pop_i,
  output ecce_pkg::item_t       q_item_o
);
  import ecce_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       keep;
  logic       push;
  logic       en_bit;

  always_comb begin
    en_bit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (item_i.iface == 2'(i) && i < Ifaces) en_bit = iface_en_i[i];
    end
    case (item_i.kind)
      KIND_PKT:  keep = en_bit;
      KIND_TICK: keep = 1'b1;
      KIND_CONS: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && keep;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

// File: sv/ecce_back.sv
// Back end: connection table and the sequencer that walks it per item; when not
// stalled, it emits one command per cycle via an output register. Uses ecce_pkg.
`default_nettype none
module ecce_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  output logic                      q_pop_o,
  input  wire ecce_pkg::item_t      q_item_i,
  input  wire logic [3:0]           timeout_i,
  input  wire logic [3:0]           retry_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                action_o,
  output logic [1:0]                out_iface_o,
  output logic [ecce_pkg::MacW-1:0] dst_mac_o,
  output logic [7:0]                out_conn_o,
  output logic [7:0]                out_seq_o,
  output logic [3:0]                slot_o,
  output logic                      last_o,
  output ecce_pkg::back_status_t    status_o
);
  import ecce_pkg::*;

  logic [1:0]      st_q   [Slots];
  logic [MacW-1:0] mac_q  [Slots];
  logic [7:0]      conn_q [Slots];
  logic [1:0]      ifc_q  [Slots];
  logic            outs_q [Slots];
  logic            isd_q  [Slots];
  logic [4:0]      tmo_q  [Slots];
  logic [4:0]      rty_q  [Slots];
  logic [7:0]      sseq_q [Slots];
  logic [7:0]      rseq_q [Slots];
  logic            stl_q  [Slots];
  logic            pend_q [Slots];

  back_state_e state_q, state_d;
  item_t   it_q;
  logic [SlotW-1:0] idx_q;
  logic          hit_q, free_q;
  logic [SlotW-1:0] hit_s_q, free_s_q;
  logic          emit2_q;
  logic          ov_q;
  // command offered to the output register this cycle
  logic        c_v;
  logic [2:0]  c_act;
  logic [1:0]  c_ifc;
  logic [MacW-1:0] c_mac;
  logic [7:0]  c_conn, c_seq;
  logic        c_last;
  logic [SlotW-1:0] c_slot;
  logic        emit;
  logic        adv;
  logic [SlotW-1:0] s;
  logic        found;
  logic [4:0]  tdec [Slots];
  logic [4:0]  rdec [Slots];
  logic [Slots-1:0] tick_hit;
  logic        later_hit;
  logic        is_last_idx;
  logic [7:0]  nseq;

  assign found = hit_q || free_q;
  assign s     = hit_q ? hit_s_q : free_s_q;
  assign is_last_idx = (idx_q == SlotW'(Slots - 1));
  assign adv   = !ov_q || !out_stall_i;
  assign emit  = adv && c_v;
  assign status_o.busy = (state_q != B_IDLE);
  assign out_valid_o   = ov_q;

  // A slot's tick outcome depends only on its own entry, so the slots not yet
  // visited tell whether the current tick command is the final one.
  always_comb begin
    for (int j = 0; j < Slots; j++) begin
      tdec[j] = (tmo_q[j] != 5'd0) ? tmo_q[j] - 5'd1 : 5'd0;
      rdec[j] = (rty_q[j] != 5'd0) ? rty_q[j] - 5'd1 : 5'd0;
      tick_hit[j] = outs_q[j] ? (tdec[j] == 5'd0 && rdec[j] != 5'd0)
                              : (stl_q[j] && pend_q[j]);
    end
    later_hit = 1'b0;
    for (int j = 0; j < Slots; j++) begin
      if (j > int'(idx_q) && tick_hit[j]) later_hit = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    c_v = 1'b0; c_act = ACT_ACK; c_ifc = it_q.iface; c_mac = it_q.mac;
    c_conn = 8'd0; c_seq = 8'd0; c_last = 1'b0; c_slot = s;
    nseq = sseq_q[s] + 8'd1;
    unique case (state_q)
      B_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        unique case (q_item_i.kind)
          KIND_PKT:  state_d = B_SCAN;
          KIND_TICK: state_d = B_TICK;
          default:   state_d = B_IDLE;
        endcase
      end
      B_SCAN: if (is_last_idx) state_d = B_PKT;
      B_PKT: if (adv) begin
        state_d = B_IDLE;
        if (found) begin
          case (it_q.pkt_type)
            PT_INITA: begin
              c_v = 1'b1; c_act = ACT_INITB; c_conn = it_q.conn_no; c_last = 1'b1;
            end
            PT_DATA: begin
              c_v = 1'b1; c_act = ACT_ACK; c_conn = conn_q[s]; c_seq = it_q.seq_no;
              if (st_q[s] == ST_UNUSED || (st_q[s] == ST_OPEN && it_q.seq_no != rseq_q[s]))
                state_d = B_EMIT2;
              else c_last = 1'b1;
            end
            PT_ACK: if (st_q[s] == ST_OPEN && pend_q[s]) begin
              c_v = 1'b1; c_act = ACT_NEWDATA; c_ifc = ifc_q[s]; c_mac = mac_q[s];
              c_conn = conn_q[s]; c_seq = nseq; c_last = 1'b1;
            end
            PT_DISC: begin
              c_v = 1'b1; c_act = ACT_OFFER; c_last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      B_EMIT2: if (adv) begin
        c_v = 1'b1; c_last = 1'b1;
        if (emit2_q) begin
          c_act = ACT_OFFER;
        end else begin
          c_act = ACT_DELIVER; c_conn = conn_q[s]; c_seq = it_q.seq_no;
        end
        state_d = B_IDLE;
      end
      B_TICK: if (adv) begin
        if (outs_q[idx_q]) begin
          if (tdec[idx_q] == 5'd0 && rdec[idx_q] != 5'd0) begin
            c_v = 1'b1; c_act = ACT_RESEND;
            c_seq = isd_q[idx_q] ? sseq_q[idx_q] : 8'd0;
          end
        end else if (stl_q[idx_q] && pend_q[idx_q]) begin
          c_v = 1'b1; c_act = ACT_NEWDATA; c_seq = sseq_q[idx_q] + 8'd1;
        end
        c_ifc = ifc_q[idx_q]; c_mac = mac_q[idx_q]; c_conn = conn_q[idx_q];
        c_slot = idx_q; c_last = !later_hit;
        if (is_last_idx) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ov_q     <= 1'b0;
      idx_q    <= '0;
      it_q     <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      hit_s_q  <= '0;
      free_s_q <= '0;
      emit2_q  <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        st_q[i] <= ST_UNUSED; mac_q[i] <= '0; conn_q[i] <= '0; ifc_q[i] <= '0;
        outs_q[i] <= 1'b0; isd_q[i] <= 1'b0; tmo_q[i] <= '0; rty_q[i] <= '0;
        sseq_q[i] <= '0; rseq_q[i] <= '0; stl_q[i] <= 1'b0; pend_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        B_IDLE: if (q_valid_i) begin
          it_q <= q_item_i; idx_q <= '0;
          hit_q <= 1'b0; free_q <= 1'b0;
          if (q_item_i.kind == KIND_CONS) begin
            for (int i = 0; i < Slots; i++)
              if (st_q[i] == ST_OPEN) begin stl_q[i] <= 1'b1; pend_q[i] <= 1'b1; end
          end
        end
        B_SCAN: begin
          if (!hit_q && mac_q[idx_q] == it_q.mac && conn_q[idx_q] == it_q.conn_no) begin
            hit_q <= 1'b1; hit_s_q <= idx_q;
          end
          if (!free_q && st_q[idx_q] == ST_UNUSED) begin
            free_q <= 1'b1; free_s_q <= idx_q;
          end
          if (!is_last_idx) idx_q <= idx_q + SlotW'(1);
        end
        B_PKT: if (adv && found) begin
          emit2_q <= (st_q[s] == ST_UNUSED);
          case (it_q.pkt_type)
            PT_INITA: begin
              ifc_q[s] <= it_q.iface; st_q[s] <= ST_INITB; mac_q[s] <= it_q.mac;
              conn_q[s] <= it_q.conn_no; outs_q[s] <= 1'b1; isd_q[s] <= 1'b0;
              tmo_q[s] <= 5'(timeout_i); rty_q[s] <= 5'(retry_i);
            end
            PT_INITC: if (st_q[s] == ST_INITB) begin
              outs_q[s] <= 1'b0; tmo_q[s] <= '0; rty_q[s] <= '0; st_q[s] <= ST_OPEN;
            end
            PT_DATA: if (st_q[s] != ST_UNUSED) rseq_q[s] <= it_q.seq_no;
            PT_ACK: if (st_q[s] == ST_OPEN) begin
              if (pend_q[s]) begin
                sseq_q[s] <= nseq; pend_q[s] <= 1'b0; outs_q[s] <= 1'b1;
                isd_q[s] <= 1'b1; tmo_q[s] <= 5'(timeout_i); rty_q[s] <= 5'(retry_i);
              end else begin
                outs_q[s] <= 1'b0; tmo_q[s] <= '0; rty_q[s] <= '0;
              end
            end
            PT_RESET: begin
              outs_q[s] <= 1'b0; tmo_q[s] <= '0; rty_q[s] <= '0; st_q[s] <= ST_UNUSED;
            end
            default: ;
          endcase
        end
        B_TICK: if (adv) begin
          if (outs_q[idx_q]) begin
            if (tdec[idx_q] != 5'd0) begin
              tmo_q[idx_q] <= tdec[idx_q];
            end else if (rdec[idx_q] == 5'd0) begin
              // give up: drop the unacknowledged packet
              outs_q[idx_q] <= 1'b0; tmo_q[idx_q] <= '0; rty_q[idx_q] <= '0;
            end else begin
              rty_q[idx_q] <= rdec[idx_q]; tmo_q[idx_q] <= 5'(timeout_i);
            end
          end else if (stl_q[idx_q]) begin
            stl_q[idx_q] <= 1'b0;
            if (pend_q[idx_q]) begin
              sseq_q[idx_q] <= sseq_q[idx_q] + 8'd1; pend_q[idx_q] <= 1'b0;
              outs_q[idx_q] <= 1'b1; isd_q[idx_q] <= 1'b1;
              tmo_q[idx_q] <= 5'(timeout_i); rty_q[idx_q] <= 5'(retry_i);
            end
          end
          if (!is_last_idx) idx_q <= idx_q + SlotW'(1);
        end
        default: ;
      endcase
    end
  end

  // output register load
  always_ff @(posedge clk_i) begin
    if (emit) begin
      action_o <= c_act; out_iface_o <= c_ifc; dst_mac_o <= c_mac;
      out_conn_o <= c_conn; out_seq_o <= c_seq; slot_o <= 4'(c_slot);
      last_o <= c_last;
    end
  end
endmodule
`default_nettype wire

// File: sv/ethernet_console_connection_engine_top.sv
// Raw-ethernet console connection engine.
// Input channel in_valid_i/in_stall_o carries one transaction: a packet
// header, a timer tick or a console-output notice. Output channel
// out_valid_o/out_stall_i carries transmit or deliver commands; last_o
// marks the final command of one input transaction.
// A two-entry queue separates the classifier from the table sequencer.
// Packets: the item is popped, the table lookup scan visits every slot, then
// commands follow at one per cycle while the receiver does not stall (at most
// two). Ticks: the item is popped, then the sequencer walks one slot per cycle
// while not stalled. Console notices take effect when popped. The serial walk
// over the connection table sets the throughput.
// Reset empties the queue and marks every slot unused; configuration
// returns to interfaces disabled, timeout 4 and retry 3.
// When the receiver stalls, the sequencer holds at its next command or slot;
// the queue takes transactions until both entries fill, then in_stall_o rises.
// Config writes are taken any cycle and are meant for idle periods only.
`default_nettype none
module ethernet_console_connection_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [1:0]  iface_i,
  input  wire logic [47:0] src_mac_i,
  input  wire logic [7:0]  pkt_type_i,
  input  wire logic [7:0]  conn_no_i,
  input  wire logic [7:0]  seq_no_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       action_o,
  output logic [1:0]       out_iface_o,
  output logic [47:0]      dst_mac_o,
  output logic [7:0]       out_conn_o,
  output logic [7:0]       out_seq_o,
  output logic [3:0]       slot_o,
  output logic             last_o
);
  import ecce_pkg::*;
  `include "ethernet_console_connection_engine_top_macros.svh"

  logic [3:0] en_q, tmo_q, rty_q;
  item_t item, q_item;
  logic  q_valid, q_pop;
  logic  pop_work;
  back_status_t bst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0; tmo_q <= TimeoutReset; rty_q <= RetryReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IFACE_EN: en_q  <= cfg_data_i;
        CFG_TIMEOUT:  tmo_q <= cfg_data_i;
        CFG_RETRY:    rty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item = '{kind: kind_i, iface: iface_i, mac: src_mac_i,
                  pkt_type: pkt_type_i, conn_no: conn_no_i, seq_no: seq_no_i};

  ecce_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .item_i(item), .iface_en_i(en_q),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  ecce_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .timeout_i(tmo_q), .retry_i(rty_q), .out_valid_o, .out_stall_i, .action_o,
    .out_iface_o, .dst_mac_o, .out_conn_o, .out_seq_o, .slot_o, .last_o,
    .status_o(bst)
  );

  assign pop_work = q_pop && (q_item.kind == KIND_PKT || q_item.kind == KIND_TICK);

  `ECCE_ASSERT(a_pop_idle, !q_pop || !bst.busy, "queue popped while sequencer busy")
  `ECCE_ASSERT_NEXT(a_pop_busy, pop_work, bst.busy, "sequencer did not start on popped item")
  `ECCE_ASSERT(a_slot_range, !out_valid_o || 32'(slot_o) < Slots, "slot out of range")
endmodule
`default_nettype wire
